### hw/rtl/avscp_pkg.sv
`default_nettype none

package avscp_pkg;

	// Default width of the sequence and picture counters.
	localparam int COUNT_BITS_DEF = 20;

	// Width of the score field and the score reported for a plausible stream.
	localparam int SCORE_BITS = 7;
	localparam logic [SCORE_BITS-1:0] SCORE_MATCH = 7'd51;
	localparam logic [SCORE_BITS-1:0] SCORE_NONE = 7'd0;

	// Reset value of the profile register.
	localparam logic [7:0] PROFILE_RESET = 8'h20;

	// Start code prefix 00 00 01 and the codes that follow it.
	localparam logic [23:0] START_PREFIX = 24'h000001;
	localparam logic [7:0] CODE_SEQ = 8'hB0;
	localparam logic [7:0] CODE_PIC_I = 8'hB3;
	localparam logic [7:0] CODE_REJ = 8'hB4;
	localparam logic [7:0] CODE_PIC_P = 8'hB6;
	localparam logic [7:0] CODE_LAST_OK = 8'hB7;

	// Verdict snapshot control handed from the scanner to the verdict stage.
	typedef struct packed {
		logic load;
		logic rejected;
	} snap_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/avscp_if.sv
`default_nettype none

// Byte stream channel.
interface avscp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// Verdict channel.
interface avscp_verdict_if
	import avscp_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [SCORE_BITS-1:0] score;
	logic                  matched;

	modport source (output valid, output score, output matched, input ready);
	modport sink (input valid, input score, input matched, output ready);
endinterface

`default_nettype wire

### hw/rtl/avscp_scan.sv
`default_nettype none

module avscp_scan
	import avscp_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [7:0]            profile_id,
	input  wire logic                  move,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  last_byte,
	output snap_ctl_t                  snap,
	output logic      [COUNT_BITS-1:0] seq_count,
	output logic      [COUNT_BITS-1:0] pic_count
);

	logic [31:0]           hist_q;
	logic [7:0]            slice_q;
	logic [COUNT_BITS-1:0] seq_q;
	logic [COUNT_BITS-1:0] pic_q;
	logic                  await_q;
	logic                  rej_q;

	logic [31:0]           hist_n;
	logic [7:0]            slice_n;
	logic [COUNT_BITS-1:0] seq_n;
	logic [COUNT_BITS-1:0] pic_n;
	logic                  await_n;
	logic                  rej_n;
	logic [31:0]           hist_shift;

	assign hist_shift = {hist_q[23:0], data_byte};

	// Next scan state for the byte in the input register.
	always_comb begin
		hist_n = hist_q;
		slice_n = slice_q;
		seq_n = seq_q;
		pic_n = pic_q;
		await_n = await_q;
		rej_n = rej_q;
		if (!rej_q) begin
			await_n = 1'b0;
			if (await_q && (data_byte != profile_id)) begin
				rej_n = 1'b1;
			end else begin
				hist_n = hist_shift;
				if (hist_shift[31:8] == START_PREFIX) begin
					if ((data_byte < CODE_SEQ) && (data_byte < slice_q)) begin
						rej_n = 1'b1;
					end else begin
						slice_n = (data_byte < CODE_SEQ) ? data_byte : 8'h00;
						if (data_byte == CODE_SEQ) begin
							seq_n = (seq_q == '1) ? seq_q : seq_q + 1'b1;
							await_n = 1'b1;
						end else if ((data_byte == CODE_PIC_I) || (data_byte == CODE_PIC_P)) begin
							pic_n = (pic_q == '1) ? pic_q : pic_q + 1'b1;
						end else if ((data_byte == CODE_REJ) || (data_byte > CODE_LAST_OK)) begin
							rej_n = 1'b1;
						end
					end
				end
			end
		end
	end

	// A buffer that ends right after a sequence code sees a zero profile byte.
	assign snap.load = move && last_byte;
	assign snap.rejected = rej_n || (await_n && (profile_id != 8'h00));
	assign seq_count = seq_n;
	assign pic_count = pic_n;

	// Scan state; the last byte of a buffer returns it to the start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '1;
			slice_q <= '0;
			seq_q <= '0;
			pic_q <= '0;
			await_q <= 1'b0;
			rej_q <= 1'b0;
		end else if (move) begin
			if (last_byte) begin
				hist_q <= '1;
				slice_q <= '0;
				seq_q <= '0;
				pic_q <= '0;
				await_q <= 1'b0;
				rej_q <= 1'b0;
			end else begin
				hist_q <= hist_n;
				slice_q <= slice_n;
				seq_q <= seq_n;
				pic_q <= pic_n;
				await_q <= await_n;
				rej_q <= rej_n;
			end
		end
	end

	// The end of a buffer leaves a clean scanner behind.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		move && last_byte |=> (hist_q == '1) && (slice_q == '0) && (seq_q == '0)
			&& (pic_q == '0) && !await_q && !rej_q)
		else $error("scan state not cleared after last byte");

	// A rejected buffer freezes its counters until it ends.
	a_frozen_when_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		rej_q && !(move && last_byte) |=> $stable(seq_q) && $stable(pic_q))
		else $error("counters moved after rejection");

	// Within a buffer the counters never go backwards.
	a_counts_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(move && last_byte) |=> (seq_q >= $past(seq_q)) && (pic_q >= $past(pic_q)))
		else $error("counter decreased within a buffer");

endmodule

`default_nettype wire

### hw/rtl/avscp_verdict.sv
`default_nettype none

module avscp_verdict
	import avscp_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  snap_ctl_t                  snap,
	input  wire logic [COUNT_BITS-1:0] seq_count,
	input  wire logic [COUNT_BITS-1:0] pic_count,
	output logic                       snap_ready,
	avscp_verdict_if.source            verdict
);

	localparam int PROD_BITS = COUNT_BITS + 4;

	logic                  valid_s2;
	logic                  rej_s2;
	logic [COUNT_BITS-1:0] seq_s2;
	logic [COUNT_BITS-1:0] pic_s2;
	logic                  out_valid_q;
	logic [SCORE_BITS-1:0] score_q;
	logic                  matched_q;

	logic                  out_free;
	logic                  s2_move;
	logic [PROD_BITS-1:0]  seq_ext;
	logic [PROD_BITS-1:0]  pic_ext;
	logic [PROD_BITS-1:0]  seq_x9;
	logic [PROD_BITS-1:0]  pic_x10;
	logic                  pass;

	// Handshake between the snapshot stage and the output register.
	assign out_free = !out_valid_q || verdict.ready;
	assign s2_move = valid_s2 && out_free;
	assign snap_ready = !valid_s2 || out_free;

	// Score test: at least one sequence and 9 * seq <= 10 * pic.
	assign seq_ext = {4'b0000, seq_s2};
	assign pic_ext = {4'b0000, pic_s2};
	assign seq_x9 = (seq_ext << 3) + seq_ext;
	assign pic_x10 = (pic_ext << 3) + (pic_ext << 1);
	assign pass = !rej_s2 && (seq_s2 != '0) && (seq_x9 <= pic_x10);

	// Snapshot stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (snap_ready) begin
			valid_s2 <= snap.load;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap.load) begin
			rej_s2 <= snap.rejected;
			seq_s2 <= seq_count;
			pic_s2 <= pic_count;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			score_q <= pass ? SCORE_MATCH : SCORE_NONE;
			matched_q <= pass;
		end
	end

	assign verdict.valid = out_valid_q;
	assign verdict.score = score_q;
	assign verdict.matched = matched_q;

	// A waiting snapshot is not lost while the output is stalled.
	a_snap_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(seq_s2) && $stable(pic_s2)
			&& $stable(rej_s2))
		else $error("snapshot changed while output stalled");

	// A result reaches the output in the cycle after its snapshot moves.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s2_move |=> out_valid_q)
		else $error("snapshot moved without producing a result");

endmodule

`default_nettype wire

### hw/rtl/avs_start_code_probe.sv
`default_nettype none

// AVS start code probe: takes one byte of a buffer per clock, tracking 00 00 01 xx start codes
// with a 32-bit window, the slice order, and saturating sequence and picture counts. The
// byte flagged last_byte produces one verdict (score 51 with matched high for a plausible
// stream, otherwise 0) via the snapshot stage and output register; other bytes produce nothing.
// A full byte stream is sustained at one byte per cycle, set by the scan update of the
// window and counters, while no last byte is held back; a stalled verdict only blocks input
// once the snapshot stage and output register are both full and a later last byte arrives.
// profile_id may be written through cfg_we/cfg_data only while the probe is idle.
module avs_start_code_probe
	import avscp_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data,
	avscp_byte_if.sink      stream,
	avscp_verdict_if.source verdict
);

	logic [7:0] profile_id_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       snap_ready;
	logic       move_s1;

	snap_ctl_t             snap;
	logic [COUNT_BITS-1:0] seq_count;
	logic [COUNT_BITS-1:0] pic_count;

	// Profile register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_id_q <= PROFILE_RESET;
		end else if (cfg_we) begin
			profile_id_q <= cfg_data;
		end
	end

	// Only a last byte needs room in the verdict stage.
	assign move_s1 = valid_s1 && (!last_s1 || snap_ready);
	assign stream.ready = !valid_s1 || move_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1 <= stream.data_byte;
			last_s1 <= stream.last_byte;
		end
	end

	avscp_scan #(
		.COUNT_BITS(COUNT_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.profile_id(profile_id_q),
		.move(move_s1),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.snap(snap),
		.seq_count(seq_count),
		.pic_count(pic_count)
	);

	avscp_verdict #(
		.COUNT_BITS(COUNT_BITS)
	) u_verdict (
		.clk(clk),
		.arst_n(arst_n),
		.snap(snap),
		.seq_count(seq_count),
		.pic_count(pic_count),
		.snap_ready(snap_ready),
		.verdict(verdict)
	);

	// Input is only held back by a pending last byte that cannot move on.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!stream.ready |-> valid_s1 && last_s1 && !snap_ready)
		else $error("input stalled without a blocked last byte");

	// A last byte only leaves the input register into a free snapshot stage.
	a_snap_room: assert property (@(posedge clk) disable iff (!arst_n)
		snap.load |-> snap_ready)
		else $error("verdict snapshot overwritten");

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import avscp_pkg::*;

	// One verdict as the probe reports it.
	typedef struct packed {
		logic [SCORE_BITS-1:0] score;
		logic                  matched;
	} verdict_t;

	// One row of the directed table; pinned rows carry a verdict typed in by hand.
	typedef struct packed {
		logic [7:0]            data;
		logic                  last;
		logic                  pinned;
		logic [SCORE_BITS-1:0] score;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_BYTES = 265;
	localparam int NUM_PHASES = 5;
	localparam int SETTLE_CYCLES = 4;

	// Codes that are neither slices, sequences, pictures nor rejects.
	localparam logic [7:0] CODE_NEUTRAL [4] = '{8'hB1, 8'hB2, 8'hB5, CODE_LAST_OK};
	localparam logic [7:0] CODE_SLICE_MAX = CODE_SEQ - 8'd1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [7:0]            cfg_data;
	logic                  pin_valid;
	logic [SCORE_BITS-1:0] pin_score;

	avscp_byte_if bytes_ch ();
	avscp_verdict_if verdict_ch ();

	avs_start_code_probe u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.stream  (bytes_ch),
		.verdict (verdict_ch)
	);

	always #10 clk = ~clk;

	// Predictor state: a private copy of the scanner and its profile register.
	logic [31:0]               win;
	logic [7:0]                slice_floor;
	logic [COUNT_BITS_DEF-1:0] seq_cnt;
	logic [COUNT_BITS_DEF-1:0] pic_cnt;
	logic                      want_profile;
	logic                      dead;
	logic [7:0]                profile_reg;

	verdict_t   pending_verdicts [$];
	logic [7:0] buf_bytes [$];
	int         fail_count = 0;
	int         verdicts_seen = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;

	stim_row_t directed_rows [23] = '{
		// A buffer of one byte right after reset holds no sequence.
		'{8'hFF, 1'b1, 1'b1, SCORE_NONE},
		// One sequence with the right profile and one I picture.
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h01, 1'b0, 1'b0, SCORE_NONE},
		'{CODE_SEQ, 1'b0, 1'b0, SCORE_NONE},
		'{PROFILE_RESET, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h01, 1'b0, 1'b0, SCORE_NONE},
		'{CODE_PIC_I, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b1, 1'b1, SCORE_MATCH},
		// The buffer ends right on a sequence code, so the profile byte reads as zero.
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h01, 1'b0, 1'b0, SCORE_NONE},
		'{CODE_SEQ, 1'b1, 1'b1, SCORE_NONE},
		// A P picture followed by the reject code.
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h01, 1'b0, 1'b0, SCORE_NONE},
		'{CODE_PIC_P, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h00, 1'b0, 1'b0, SCORE_NONE},
		'{8'h01, 1'b0, 1'b0, SCORE_NONE},
		'{CODE_REJ, 1'b1, 1'b1, SCORE_NONE}
	};

	// Return the scanner to the start of a buffer; the profile is kept.
	function automatic void probe_clear();
		win = '1;
		slice_floor = '0;
		seq_cnt = '0;
		pic_cnt = '0;
		want_profile = 1'b0;
		dead = 1'b0;
	endfunction

	// Advance the scanner by one byte; on the last byte give the verdict.
	function automatic void probe_byte(input logic [7:0] b, input logic lst,
			output logic emit, output logic [SCORE_BITS-1:0] sc);
		logic       skip;
		logic [7:0] code;
		skip = 1'b0;
		emit = 1'b0;
		sc = SCORE_NONE;
		if (!dead) begin
			// The byte after a sequence code must equal the profile.
			if (want_profile) begin
				want_profile = 1'b0;
				if (b != profile_reg) begin
					dead = 1'b1;
					skip = 1'b1;
				end
			end
			if (!skip) begin
				win = {win[23:0], b};
				if (win[31:8] == START_PREFIX) begin
					code = win[7:0];
					// Slice codes sit below the sequence code and may not go down.
					if (code < CODE_SEQ && code < slice_floor) begin
						dead = 1'b1;
					end else begin
						slice_floor = (code < CODE_SEQ) ? code : 8'h00;
						if (code == CODE_SEQ) begin
							if (seq_cnt != '1) seq_cnt++;
							want_profile = 1'b1;
						end else if (code == CODE_PIC_I || code == CODE_PIC_P) begin
							if (pic_cnt != '1) pic_cnt++;
						end else if (code == CODE_REJ || code > CODE_LAST_OK) begin
							dead = 1'b1;
						end
					end
				end
			end
		end
		if (lst) begin
			// A missing profile byte reads as zero.
			if (!dead && want_profile && profile_reg != 8'h00) dead = 1'b1;
			if (!dead && seq_cnt != '0 && 64'(seq_cnt) * 64'd9 <= 64'(pic_cnt) * 64'd10)
				sc = SCORE_MATCH;
			emit = 1'b1;
			probe_clear();
		end
	endfunction

	task automatic flag_mismatch(input string what);
		$display("%0t MISMATCH: %s", $time, what);
		fail_count++;
	endtask

	// Offer one request and hold it until taken; bursts sometimes end in random gaps.
	task automatic send_byte(input logic [7:0] b, input logic lst, input logic pv,
			input logic [SCORE_BITS-1:0] ps);
		int gap;
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		bytes_ch.last_byte <= lst;
		pin_valid <= pv;
		pin_score <= ps;
		do @(posedge clk); while (!bytes_ch.ready);
		@(negedge clk);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				bytes_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Stop sending until every verdict is in, then let the pipeline settle.
	task automatic drain_verdicts();
		bytes_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_profile(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		profile_reg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Build one buffer: mostly start code sequences with random content, some noise.
	task automatic make_buffer();
		int         kind;
		logic [7:0] floor_gen;
		logic [7:0] code;
		buf_bytes.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 12)) buf_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		floor_gen = 8'h00;
		repeat ($urandom_range(0, 6)) begin
			repeat ($urandom_range(0, 2)) buf_bytes.push_back(8'($urandom_range(0, 255)));
			kind = $urandom_range(0, 19);
			if (kind == 19) begin
				// A prefix one zero short.
				buf_bytes.push_back(8'h00);
				buf_bytes.push_back(8'h01);
				buf_bytes.push_back(CODE_PIC_I);
			end else begin
				buf_bytes.push_back(8'h00);
				buf_bytes.push_back(8'h00);
				buf_bytes.push_back(8'h01);
				if (kind < 5) begin
					code = CODE_SEQ;
				end else if (kind < 12) begin
					code = (kind % 2 == 0) ? CODE_PIC_I : CODE_PIC_P;
				end else if (kind < 16) begin
					// Slices mostly climb; now and then one drops back.
					if ($urandom_range(0, 7) == 0)
						code = 8'($urandom_range(0, CODE_SLICE_MAX));
					else
						code = 8'($urandom_range(floor_gen, CODE_SLICE_MAX));
				end else if (kind < 18) begin
					code = CODE_NEUTRAL[$urandom_range(0, 3)];
				end else if ($urandom_range(0, 1) == 0) begin
					code = CODE_REJ;
				end else begin
					code = 8'($urandom_range(CODE_LAST_OK + 1, 255));
				end
				buf_bytes.push_back(code);
				floor_gen = (code < CODE_SEQ) ? code : 8'h00;
				if (code == CODE_SEQ)
					buf_bytes.push_back(($urandom_range(0, 9) == 0) ?
						8'($urandom_range(0, 255)) : profile_reg);
			end
		end
		// Sometimes the buffer ends right on a sequence code.
		if ($urandom_range(0, 5) == 0) begin
			buf_bytes.push_back(8'h00);
			buf_bytes.push_back(8'h00);
			buf_bytes.push_back(8'h01);
			buf_bytes.push_back(CODE_SEQ);
		end else begin
			buf_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Monitor: predict on each accepted request, check each verdict, watch for a hang.
	always @(posedge clk) begin
		logic                  emit;
		logic [SCORE_BITS-1:0] sc;
		verdict_t              want;
		if (arst_n) begin
			if (bytes_ch.valid && bytes_ch.ready) begin
				probe_byte(bytes_ch.data_byte, bytes_ch.last_byte, emit, sc);
				if (emit) begin
					if (pin_valid) sc = pin_score;
					want.score = sc;
					want.matched = (sc != SCORE_NONE);
					pending_verdicts.push_back(want);
				end
			end
			if (verdict_ch.valid && verdict_ch.ready) begin
				verdicts_seen++;
				if (pending_verdicts.size() == 0) begin
					flag_mismatch($sformatf("verdict with none expected, score %0d",
						verdict_ch.score));
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict_ch.score !== want.score)
						flag_mismatch($sformatf("verdict %0d score %0d, expected %0d",
							verdicts_seen, verdict_ch.score, want.score));
					if (verdict_ch.matched !== want.matched)
						flag_mismatch($sformatf("verdict %0d matched %0b, expected %0b",
							verdicts_seen, verdict_ch.matched, want.matched));
				end
			end
			if ((bytes_ch.valid && bytes_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// Receiver: stall patterns of its own, plus one long hold-off to back up the probe.
	initial begin
		int mode;
		int span;
		bit held;
		held = 1'b0;
		verdict_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && verdicts_seen >= 8) begin
				held = 1'b1;
				@(negedge clk);
				verdict_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				span = $urandom_range(5, 60);
				repeat (span) begin
					@(negedge clk);
					case (mode)
						0: verdict_ch.ready <= 1'b1;
						1: verdict_ch.ready <= 1'($urandom_range(0, 1));
						default: verdict_ch.ready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// Sender: reset, the directed table, then random phases under several profiles.
	initial begin
		int         sent;
		logic [7:0] prof;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 8'h00;
		bytes_ch.valid = 1'b0;
		bytes_ch.data_byte = 8'h00;
		bytes_ch.last_byte = 1'b0;
		pin_valid = 1'b0;
		pin_score = SCORE_NONE;
		profile_reg = PROFILE_RESET;
		probe_clear();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].last,
				directed_rows[i].pinned, directed_rows[i].score);
		drain_verdicts();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// The first phase keeps the reset profile; the rest write a new one.
			if (phase > 0) begin
				case (phase)
					1: prof = 8'h00;
					2: prof = 8'hFF;
					default: prof = 8'($urandom_range(0, 255));
				endcase
				set_profile(prof);
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				make_buffer();
				foreach (buf_bytes[j])
					send_byte(buf_bytes[j], j == buf_bytes.size() - 1, 1'b0, SCORE_NONE);
				sent += buf_bytes.size();
			end
			drain_verdicts();
		end

		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
